>>> src/rost_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the ray versus oriented box slab test
package rost_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int NAXES = 3;
   localparam int DIR_W = 16;
   localparam int HALF_W = 24;
   localparam int ROW_W = 3 * DIR_W;
   localparam int DIST_W = 31;
   localparam int T_W = 32;
   localparam int FRAC_W = 14;

   // local origin fraction part and local direction sums
   localparam int PL_W = DIR_W + FRAC_W + 1;
   localparam int SL_W = PL_W + 2;
   localparam int SLR_W = SL_W - FRAC_W;
   localparam int PD_W = 2 * DIR_W;
   localparam int SD_W = PD_W + 2;
   localparam int LDIR_W = SD_W - FRAC_W;
   localparam int DMAG_W = LDIR_W;

   // slab numerator magnitude is clamped to 2^48
   localparam int NMAG_W = 49;
   localparam int NUM_W = NMAG_W + FRAC_W;
   localparam int QBITS = T_W;
   localparam int DIV_LAT = QBITS + 2;

   localparam int REG_IDX_W = 3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_DIR_X    = 3'd3,
      REG_DIR_Y    = 3'd4,
      REG_DIR_Z    = 3'd5,
      REG_MAX_DIST = 3'd6
   } reg_idx_type;

   typedef logic signed [DIR_W-1:0] dir_type;
   typedef logic signed [T_W-1:0] t_type;

   localparam t_type T_MAX = 32'sh7fff_ffff;
   localparam t_type T_MIN = 32'sh8000_0000;

   localparam logic [DIST_W-1:0] NEAR_MARGIN = 31'd9830;
   localparam logic [DIST_W-1:0] FAR_MARGIN = 31'd36044;
   localparam dir_type DIR_X_RESET = 16'sd16384;

   typedef struct packed {
      logic [NAXES-1:0] dzero;
      logic [NAXES-1:0] in_slab;
   } ax_flags_type;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] hit_dist;
      logic              blocks;
   } result_type;

endpackage

>>> src/rost_if.sv
`timescale 1ns / 1ps
// box request and test result channel interfaces
interface rost_req_if import rost_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] box_center_x;
   logic [COORD_WIDTH-1:0] box_center_y;
   logic [COORD_WIDTH-1:0] box_center_z;
   logic [HALF_W-1:0]      box_half_x;
   logic [HALF_W-1:0]      box_half_y;
   logic [HALF_W-1:0]      box_half_z;
   logic [ROW_W-1:0]       rot_row_first;
   logic [ROW_W-1:0]       rot_row_second;
   logic [ROW_W-1:0]       rot_row_third;

   modport source (
      output valid, box_center_x, box_center_y, box_center_z,
      output box_half_x, box_half_y, box_half_z,
      output rot_row_first, rot_row_second, rot_row_third,
      input  ready
   );
   modport sink (
      input  valid, box_center_x, box_center_y, box_center_z,
      input  box_half_x, box_half_y, box_half_z,
      input  rot_row_first, rot_row_second, rot_row_third,
      output ready
   );
endinterface

interface rost_rsp_if import rost_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              hit;
   logic [DIST_W-1:0] hit_distance;
   logic              blocks_sight;

   modport source (
      output valid, hit, hit_distance, blocks_sight,
      input  ready
   );
   modport sink (
      input  valid, hit, hit_distance, blocks_sight,
      output ready
   );
endinterface

>>> src/rost_div_pipe.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, saturating signed result
module rost_div_pipe import rost_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [NMAG_W-1:0] num_mag,
   input  logic [DMAG_W-1:0] den_mag,
   input  logic              neg,
   output t_type             quot
);

   logic [NUM_W-1:0]  rem_ff [0:QBITS-1];
   logic [DMAG_W-1:0] den_ff [0:QBITS-1];
   logic              neg_ff [0:QBITS];
   logic              ovf_ff [0:QBITS];
   logic [QBITS-1:0]  q_ff   [1:QBITS];
   t_type             t_ff;
   t_type             t_in;

   logic [NUM_W-1:0] num_w;

   assign num_w = {num_mag, {FRAC_W{1'b0}}};

   // quotient of 2^32 or more saturates either way
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_w;
         den_ff[0] <= den_mag;
         neg_ff[0] <= neg;
         ovf_ff[0] <= num_w >= (NUM_W'(den_mag) << QBITS);
      end
   end

   for (genvar s = 1; s <= QBITS; s++) begin : g_stage
      localparam int SH = QBITS - s;
      logic [NUM_W-1:0] sub_w;
      logic             take;
      logic [QBITS-1:0] q_prev;

      assign sub_w = NUM_W'(den_ff[s-1]) << SH;
      assign take = rem_ff[s-1] >= sub_w;

      if (s == 1) begin : g_first
         assign q_prev = '0;
      end else begin : g_next
         assign q_prev = q_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[s]   <= q_prev | (QBITS'(take) << SH);
            neg_ff[s] <= neg_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end

      if (s < QBITS) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= take ? (rem_ff[s-1] - sub_w) : rem_ff[s-1];
               den_ff[s] <= den_ff[s-1];
            end
         end
      end
   end

   always_comb begin
      if (ovf_ff[QBITS]) begin
         t_in = neg_ff[QBITS] ? T_MIN : T_MAX;
      end else if (!neg_ff[QBITS]) begin
         t_in = q_ff[QBITS][QBITS-1] ? T_MAX : $signed(q_ff[QBITS]);
      end else begin
         t_in = (q_ff[QBITS] > (QBITS'(1) << (QBITS - 1))) ? T_MIN : -$signed(q_ff[QBITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= t_in;
      end
   end

   assign quot = t_ff;

endmodule

>>> src/ray_obb_slab_test_top.sv
`timescale 1ns / 1ps
// ray versus oriented box slab test, top level
//
// req_ch carries one box per transaction: center, half extents and the three
// rotation rows. rsp_ch returns one transaction per box: hit flag, hit
// distance and the blocking flag. The ray (origin, direction, max distance)
// sits in registers written over the APB-style port (psel ... prdata); write
// them only while no box is in flight.
//
// One box is taken every cycle while the skid register is empty. Once a box
// is accepted, five stages bring it into its own frame and form the slab
// numerators, 34 stages belong to the six pipelined dividers (one quotient
// bit per stage), two stages narrow tmin and tmax, and one is the output
// register. A skid register behind the output register catches the result
// that is in flight when the receiver stalls; while it is full the whole
// pipeline holds and req_ch.ready is low. Reset empties the pipeline and
// puts the ray registers at origin 0, direction +x and max distance 0.
// The req_ch interface instance must carry the same COORD_WIDTH.
module ray_obb_slab_test_top import rost_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   localparam int DATA_W = (COORD_WIDTH > 32) ? 64 : 32,
   localparam int ADDR_W = REG_IDX_W + ((DATA_W > 32) ? 3 : 2)
) (
   input  logic              clock,
   input  logic              reset,
   rost_req_if.sink          req_ch,
   rost_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int W = COORD_WIDTH;
   localparam int DIFF_W = W + 1;
   localparam int HI_W = DIFF_W - FRAC_W;
   localparam int PH_W = HI_W + DIR_W;
   localparam int SH_W = PH_W + 2;
   localparam int O_W = SH_W + 1;
   localparam int NUM_SW = (O_W + 1 > NMAG_W + 1) ? O_W + 1 : NMAG_W + 1;

   localparam logic signed [SL_W-1:0] SL_RND = SL_W'(1) << (FRAC_W - 1);
   localparam logic signed [SD_W-1:0] SD_RND = SD_W'(1) << (FRAC_W - 1);
   localparam logic signed [NUM_SW-1:0] NUM_LIM = NUM_SW'(1) << (NMAG_W - 1);

   // ray registers
   logic signed [W-1:0] origin_ff [NAXES];
   dir_type             dir_ff [NAXES];
   logic [DIST_W-1:0]   maxd_ff;

   logic        wr_en;
   reg_idx_type wr_idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign wr_idx = reg_idx_type'(paddr[ADDR_W-1 -: REG_IDX_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NAXES; a++) begin
            origin_ff[a] <= '0;
         end
         dir_ff[0] <= DIR_X_RESET;
         dir_ff[1] <= '0;
         dir_ff[2] <= '0;
         maxd_ff   <= '0;
      end else if (wr_en) begin
         unique case (wr_idx)
            REG_ORIGIN_X: origin_ff[0] <= pwdata[W-1:0];
            REG_ORIGIN_Y: origin_ff[1] <= pwdata[W-1:0];
            REG_ORIGIN_Z: origin_ff[2] <= pwdata[W-1:0];
            REG_DIR_X:    dir_ff[0] <= pwdata[DIR_W-1:0];
            REG_DIR_Y:    dir_ff[1] <= pwdata[DIR_W-1:0];
            REG_DIR_Z:    dir_ff[2] <= pwdata[DIR_W-1:0];
            REG_MAX_DIST: maxd_ff <= pwdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (wr_idx)
         REG_ORIGIN_X: prdata = DATA_W'($unsigned(origin_ff[0]));
         REG_ORIGIN_Y: prdata = DATA_W'($unsigned(origin_ff[1]));
         REG_ORIGIN_Z: prdata = DATA_W'($unsigned(origin_ff[2]));
         REG_DIR_X:    prdata = DATA_W'($unsigned(dir_ff[0]));
         REG_DIR_Y:    prdata = DATA_W'($unsigned(dir_ff[1]));
         REG_DIR_Z:    prdata = DATA_W'($unsigned(dir_ff[2]));
         REG_MAX_DIST: prdata = DATA_W'(maxd_ff);
         default:      prdata = '0;
      endcase
   end

   // pipeline advance: held only while the skid register is full
   logic en;
   logic skid_valid_ff, skid_valid_in;
   logic out_valid_ff, out_valid_in;

   assign en = !skid_valid_ff;
   assign req_ch.ready = en;

   // stage 1: origin minus center
   logic signed [W-1:0]    ctr_w [NAXES];
   logic [HALF_W-1:0]      half_w [NAXES];
   logic [ROW_W-1:0]       rows_w [NAXES];
   logic                   v1_ff;
   logic signed [DIFF_W-1:0] diff1_ff [NAXES];
   logic [HALF_W-1:0]      half1_ff [NAXES];
   dir_type                row1_ff [NAXES][NAXES];

   assign ctr_w[0]  = $signed(req_ch.box_center_x);
   assign ctr_w[1]  = $signed(req_ch.box_center_y);
   assign ctr_w[2]  = $signed(req_ch.box_center_z);
   assign half_w[0] = req_ch.box_half_x;
   assign half_w[1] = req_ch.box_half_y;
   assign half_w[2] = req_ch.box_half_z;
   assign rows_w[0] = req_ch.rot_row_first;
   assign rows_w[1] = req_ch.rot_row_second;
   assign rows_w[2] = req_ch.rot_row_third;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NAXES; a++) begin
            diff1_ff[a] <= DIFF_W'(origin_ff[a]) - DIFF_W'(ctr_w[a]);
            half1_ff[a] <= half_w[a];
            for (int k = 0; k < NAXES; k++) begin
               row1_ff[a][k] <= rows_w[a][DIR_W*k +: DIR_W];
            end
         end
      end
   end

   // stage 2: rotation products, difference split into whole and fraction parts
   logic signed [HI_W-1:0]   hi_w [NAXES];
   logic signed [FRAC_W:0]   lo_w [NAXES];
   logic                     v2_ff;
   logic signed [PH_W-1:0]   ph2_ff [NAXES][NAXES];
   logic signed [PL_W-1:0]   pl2_ff [NAXES][NAXES];
   logic signed [PD_W-1:0]   pd2_ff [NAXES][NAXES];
   logic [HALF_W-1:0]        half2_ff [NAXES];

   always_comb begin
      for (int k = 0; k < NAXES; k++) begin
         hi_w[k] = HI_W'(diff1_ff[k] >>> FRAC_W);
         lo_w[k] = $signed({1'b0, diff1_ff[k][FRAC_W-1:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NAXES; a++) begin
            half2_ff[a] <= half1_ff[a];
            for (int k = 0; k < NAXES; k++) begin
               ph2_ff[a][k] <= PH_W'(row1_ff[a][k]) * PH_W'(hi_w[k]);
               pl2_ff[a][k] <= PL_W'(row1_ff[a][k]) * PL_W'(lo_w[k]);
               pd2_ff[a][k] <= PD_W'(row1_ff[a][k]) * PD_W'(dir_ff[k]);
            end
         end
      end
   end

   // stage 3: row sums, fraction and direction rounded half up
   logic signed [SL_W-1:0]   sl_w [NAXES];
   logic signed [SD_W-1:0]   sd_w [NAXES];
   logic                     v3_ff;
   logic signed [SH_W-1:0]   sh3_ff [NAXES];
   logic signed [SLR_W-1:0]  slr3_ff [NAXES];
   logic signed [LDIR_W-1:0] ld3_ff [NAXES];
   logic [HALF_W-1:0]        half3_ff [NAXES];

   always_comb begin
      for (int a = 0; a < NAXES; a++) begin
         sl_w[a] = SL_W'(pl2_ff[a][0]) + SL_W'(pl2_ff[a][1]) + SL_W'(pl2_ff[a][2]) + SL_RND;
         sd_w[a] = SD_W'(pd2_ff[a][0]) + SD_W'(pd2_ff[a][1]) + SD_W'(pd2_ff[a][2]) + SD_RND;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NAXES; a++) begin
            sh3_ff[a]   <= SH_W'(ph2_ff[a][0]) + SH_W'(ph2_ff[a][1]) + SH_W'(ph2_ff[a][2]);
            slr3_ff[a]  <= SLR_W'(sl_w[a] >>> FRAC_W);
            ld3_ff[a]   <= LDIR_W'(sd_w[a] >>> FRAC_W);
            half3_ff[a] <= half2_ff[a];
         end
      end
   end

   // stage 4: local origin
   logic                     v4_ff;
   logic signed [O_W-1:0]    o4_ff [NAXES];
   logic signed [LDIR_W-1:0] ld4_ff [NAXES];
   logic [HALF_W-1:0]        half4_ff [NAXES];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NAXES; a++) begin
            o4_ff[a]    <= O_W'(sh3_ff[a]) + O_W'(slr3_ff[a]);
            ld4_ff[a]   <= ld3_ff[a];
            half4_ff[a] <= half3_ff[a];
         end
      end
   end

   // stage 5: slab numerators, clamped, as sign and magnitude
   logic signed [NUM_SW-1:0] hs_w [NAXES];
   logic signed [NUM_SW-1:0] ov_w [NAXES];
   logic signed [NUM_SW-1:0] n_w [NAXES][2];
   logic signed [NUM_SW-1:0] nc_w [NAXES][2];
   logic                     v5_ff;
   logic [NMAG_W-1:0]        mag5_ff [NAXES][2];
   logic                     nneg5_ff [NAXES][2];
   logic [DMAG_W-1:0]        dmag5_ff [NAXES];
   logic                     dneg5_ff [NAXES];
   ax_flags_type             flags5_ff;

   always_comb begin
      for (int a = 0; a < NAXES; a++) begin
         hs_w[a] = NUM_SW'($signed({1'b0, half4_ff[a]}));
         ov_w[a] = NUM_SW'(o4_ff[a]);
         n_w[a][0] = -hs_w[a] - ov_w[a];
         n_w[a][1] = hs_w[a] - ov_w[a];
         for (int j = 0; j < 2; j++) begin
            if (n_w[a][j] > NUM_LIM) begin
               nc_w[a][j] = NUM_LIM;
            end else if (n_w[a][j] < -NUM_LIM) begin
               nc_w[a][j] = -NUM_LIM;
            end else begin
               nc_w[a][j] = n_w[a][j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NAXES; a++) begin
            for (int j = 0; j < 2; j++) begin
               nneg5_ff[a][j] <= nc_w[a][j][NUM_SW-1];
               mag5_ff[a][j]  <= NMAG_W'(nc_w[a][j][NUM_SW-1] ? -nc_w[a][j] : nc_w[a][j]);
            end
            dneg5_ff[a]        <= ld4_ff[a][LDIR_W-1];
            dmag5_ff[a]        <= DMAG_W'(ld4_ff[a][LDIR_W-1] ? -ld4_ff[a] : ld4_ff[a]);
            flags5_ff.dzero[a] <= ld4_ff[a] == '0;
            flags5_ff.in_slab[a] <= !(ov_w[a] < -hs_w[a] || ov_w[a] > hs_w[a]);
         end
      end
   end

   // dividers, two per axis; flags and valid travel alongside
   t_type        tq_w [NAXES][2];
   logic         vd_ff [DIV_LAT];
   ax_flags_type fd_ff [DIV_LAT];

   for (genvar a = 0; a < NAXES; a++) begin : g_axis
      for (genvar j = 0; j < 2; j++) begin : g_side
         rost_div_pipe u_div (
            .clock   (clock),
            .en      (en),
            .num_mag (mag5_ff[a][j]),
            .den_mag (dmag5_ff[a]),
            .neg     (nneg5_ff[a][j] ^ dneg5_ff[a]),
            .quot    (tq_w[a][j])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fd_ff[0] <= flags5_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            fd_ff[i] <= fd_ff[i-1];
         end
      end
   end

   // stage 6: put each slab's t values in order
   logic         v6_ff;
   t_type        tlo6_ff [NAXES];
   t_type        thi6_ff [NAXES];
   ax_flags_type flags6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NAXES; a++) begin
            tlo6_ff[a] <= (tq_w[a][0] > tq_w[a][1]) ? tq_w[a][1] : tq_w[a][0];
            thi6_ff[a] <= (tq_w[a][0] > tq_w[a][1]) ? tq_w[a][0] : tq_w[a][1];
         end
         flags6_ff <= fd_ff[DIV_LAT-1];
      end
   end

   // stage 7: narrow the interval over slabs with nonzero direction
   t_type tmin_w, tmax_w;
   logic  v7_ff;
   t_type tmin7_ff, tmax7_ff;
   logic  inok7_ff;

   always_comb begin
      tmin_w = T_MIN;
      tmax_w = T_MAX;
      for (int a = 0; a < NAXES; a++) begin
         if (!flags6_ff.dzero[a]) begin
            if (tlo6_ff[a] > tmin_w) begin
               tmin_w = tlo6_ff[a];
            end
            if (thi6_ff[a] < tmax_w) begin
               tmax_w = thi6_ff[a];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tmin7_ff <= tmin_w;
         tmax7_ff <= tmax_w;
         inok7_ff <= &(flags6_ff.in_slab | ~flags6_ff.dzero);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         for (int i = 0; i < DIV_LAT; i++) begin
            vd_ff[i] <= 1'b0;
         end
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= req_ch.valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         vd_ff[0] <= v5_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
         v6_ff <= vd_ff[DIV_LAT-1];
         v7_ff <= v6_ff;
      end
   end

   // final decision
   t_type                 hitd_w;
   logic signed [T_W:0]   maxd_s;
   logic                  ok_w;
   result_type            res_w;

   always_comb begin
      hitd_w = tmin7_ff[T_W-1] ? tmax7_ff : tmin7_ff;
      maxd_s = $signed({{(T_W + 1 - DIST_W){1'b0}}, maxd_ff});
      ok_w = inok7_ff && !(tmin7_ff > tmax7_ff) && !tmax7_ff[T_W-1]
             && ((T_W + 1)'(tmin7_ff) <= maxd_s)
             && !hitd_w[T_W-1] && ((T_W + 1)'(hitd_w) <= maxd_s);
      res_w.hit      = ok_w;
      res_w.hit_dist = ok_w ? hitd_w[DIST_W-1:0] : '0;
      res_w.blocks   = ok_w && (hitd_w[DIST_W-1:0] > NEAR_MARGIN)
                       && ((maxd_ff - hitd_w[DIST_W-1:0]) > FAR_MARGIN);
   end

   // output register and skid register
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (en) begin
         if (out_valid_ff && !rsp_ch.ready) begin
            skid_valid_in = v7_ff;
            skid_in       = res_w;
         end else begin
            out_valid_in = v7_ff;
            out_in       = res_w;
         end
      end else if (rsp_ch.ready) begin
         out_valid_in  = 1'b1;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.hit          = out_ff.hit;
   assign rsp_ch.hit_distance = out_ff.hit_dist;
   assign rsp_ch.blocks_sight = out_ff.blocks;

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_ch.ready |=> out_valid_ff && !skid_valid_ff)
      else $error("skid register did not move into the output register");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.hit |-> out_ff.hit_dist == '0 && !out_ff.blocks)
      else $error("missed box reports a distance or a blocking flag");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.hit |-> out_ff.hit_dist <= maxd_ff)
      else $error("hit distance lies beyond max distance");
`endif

endmodule

>>> tb/ray_obb_slab_test_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the ray versus oriented box slab test
module ray_obb_slab_test_top_tb;
   import rost_pkg::*;

   localparam int CW = 32;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [ROW_W-1:0] ROW_X = 48'h0000_0000_4000;
   localparam logic [ROW_W-1:0] ROW_Y = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0] ROW_Z = 48'h4000_0000_0000;
   localparam longint ONE = 65536;
   localparam longint T_HI = 64'sd2147483647;
   localparam longint T_LO = -64'sd2147483648;

   typedef struct {
      logic [CW-1:0]     center[3];
      logic [HALF_W-1:0] half[3];
      logic [ROW_W-1:0]  row[3];
   } box_type;

   typedef struct {
      box_type    box;
      bit         known;
      result_type res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   rost_req_if #(.COORD_WIDTH(CW)) req_ch ();
   rost_rsp_if rsp_ch ();

   ray_obb_slab_test_top #(.COORD_WIDTH(CW)) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   // shadow of the ray registers
   logic signed [31:0] ray_org[3];
   logic signed [15:0] ray_dir[3];
   logic [DIST_W-1:0]  ray_maxd;

   result_type hit_q[$];
   bit         fixed_known_q[$];
   result_type fixed_res_q[$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 0;
   int stall_left = 0;

   function automatic result_type predict_box_hit(box_type b);
      longint diff, hi[3], lo[3], lorg[3], ldir[3], half[3], rw[3][3];
      longint sh, sl, sd, o, d, n1, n2, t1, t2, tmp, tmin, tmax, hitd, maxd;
      bit ok;
      result_type r;
      maxd = longint'(ray_maxd);
      for (int a = 0; a < 3; a++) begin
         diff = longint'(ray_org[a]) - longint'($signed(b.center[a]));
         hi[a] = diff >>> FRAC_W;
         lo[a] = diff - hi[a] * 16384;
         half[a] = longint'(b.half[a]);
         for (int k = 0; k < 3; k++)
            rw[a][k] = longint'($signed(b.row[a][16*k +: 16]));
      end
      for (int a = 0; a < 3; a++) begin
         sh = 0; sl = 0; sd = 0;
         for (int k = 0; k < 3; k++) begin
            sh += rw[a][k] * hi[k];
            sl += rw[a][k] * lo[k];
            sd += rw[a][k] * longint'(ray_dir[k]);
         end
         lorg[a] = sh + ((sl + 8192) >>> FRAC_W);
         ldir[a] = (sd + 8192) >>> FRAC_W;
      end
      tmin = T_LO;
      tmax = T_HI;
      ok = 1;
      for (int a = 0; a < 3 && ok; a++) begin
         o = lorg[a];
         d = ldir[a];
         if (d == 0) begin
            if (o < -half[a] || o > half[a]) ok = 0;
            continue;
         end
         n1 = -half[a] - o;
         n2 = half[a] - o;
         if (n1 > (64'sd1 <<< 48)) n1 = 64'sd1 <<< 48;
         if (n1 < -(64'sd1 <<< 48)) n1 = -(64'sd1 <<< 48);
         if (n2 > (64'sd1 <<< 48)) n2 = 64'sd1 <<< 48;
         if (n2 < -(64'sd1 <<< 48)) n2 = -(64'sd1 <<< 48);
         t1 = n1 * 16384 / d;
         t2 = n2 * 16384 / d;
         if (t1 > T_HI) t1 = T_HI;
         if (t1 < T_LO) t1 = T_LO;
         if (t2 > T_HI) t2 = T_HI;
         if (t2 < T_LO) t2 = T_LO;
         if (t1 > t2) begin
            tmp = t1; t1 = t2; t2 = tmp;
         end
         if (t1 > tmin) tmin = t1;
         if (t2 < tmax) tmax = t2;
         if (tmin > tmax || tmax < 0 || tmin > maxd) ok = 0;
      end
      hitd = (tmin >= 0) ? tmin : tmax;
      if (ok && (hitd < 0 || hitd > maxd || tmin > tmax)) ok = 0;
      r = '0;
      if (ok) begin
         r.hit = 1'b1;
         r.hit_dist = hitd[DIST_W-1:0];
         r.blocks = (hitd > longint'(NEAR_MARGIN)) && (maxd - hitd > longint'(FAR_MARGIN));
      end
      return r;
   endfunction

   // monitor: predict on request, check on response, watchdog
   always @(posedge clock) begin
      result_type want, got;
      bit known;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            box_type b;
            b.center = '{req_ch.box_center_x, req_ch.box_center_y, req_ch.box_center_z};
            b.half = '{req_ch.box_half_x, req_ch.box_half_y, req_ch.box_half_z};
            b.row = '{req_ch.rot_row_first, req_ch.rot_row_second, req_ch.rot_row_third};
            known = 0;
            if (fixed_known_q.size() > 0) begin
               known = fixed_known_q.pop_front();
               want = fixed_res_q.pop_front();
            end
            if (!known) want = predict_box_hit(b);
            hit_q.insert(hit_q.size(), want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.hit = rsp_ch.hit;
            got.hit_dist = rsp_ch.hit_distance;
            got.blocks = rsp_ch.blocks_sight;
            if (hit_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected transaction: hit %0b dist %0d blocks %0b",
                           got.hit, got.hit_dist, got.blocks);
            end else begin
               want = hit_q.pop_front();
               if (want != got) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: exp hit %0b dist %0d blocks %0b,",
                               " got hit %0b dist %0d blocks %0b"},
                              want.hit, want.hit_dist, want.blocks,
                              got.hit, got.hit_dist, got.blocks);
               end
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ray_obb_slab_test_top_tb NOT OK");
            $finish;
         end
      end
   end

   // receiver stalls in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic write_ray_reg(reg_idx_type idx, logic [31:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0;
      unique case (idx)
         REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: ray_org[idx] = val;
         REG_DIR_X: ray_dir[0] = val[15:0];
         REG_DIR_Y: ray_dir[1] = val[15:0];
         REG_DIR_Z: ray_dir[2] = val[15:0];
         REG_MAX_DIST: ray_maxd = val[DIST_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_ray(logic [31:0] ox, oy, oz, logic [15:0] dx, dy, dz, logic [30:0] md);
      write_ray_reg(REG_ORIGIN_X, ox);
      write_ray_reg(REG_ORIGIN_Y, oy);
      write_ray_reg(REG_ORIGIN_Z, oz);
      write_ray_reg(REG_DIR_X, {16'h0, dx});
      write_ray_reg(REG_DIR_Y, {16'h0, dy});
      write_ray_reg(REG_DIR_Z, {16'h0, dz});
      write_ray_reg(REG_MAX_DIST, {1'b0, md});
   endtask

   task automatic send_box(box_type b);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.box_center_x <= b.center[0];
      req_ch.box_center_y <= b.center[1];
      req_ch.box_center_z <= b.center[2];
      req_ch.box_half_x <= b.half[0];
      req_ch.box_half_y <= b.half[1];
      req_ch.box_half_z <= b.half[2];
      req_ch.rot_row_first <= b.row[0];
      req_ch.rot_row_second <= b.row[1];
      req_ch.rot_row_third <= b.row[2];
      req_ch.valid <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_results_done();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (hit_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic box_type make_box(longint cx, cy, cz, longint h, logic [ROW_W-1:0] r0,
                                        logic [ROW_W-1:0] r1, logic [ROW_W-1:0] r2);
      box_type b;
      b.center = '{cx[31:0], cy[31:0], cz[31:0]};
      b.half = '{h[23:0], h[23:0], h[23:0]};
      b.row = '{r0, r1, r2};
      return b;
   endfunction

   function automatic logic [15:0] to_q14(real x);
      return 16'($rtoi(x * 16384.0 + ((x >= 0.0) ? 0.5 : -0.5)));
   endfunction

   function automatic box_type random_box();
      box_type b;
      real m[3][3], c, s, ang, t, ux, uy, uz;
      int ax;
      longint pos;
      if ($urandom_range(0, 99) < 15) begin
         // noise: any center and row value, half extents up to 16384000
         for (int a = 0; a < 3; a++) begin
            b.center[a] = $urandom();
            b.half[a] = HALF_W'($urandom_range(0, 16384000));
            b.row[a] = ROW_W'({$urandom(), $urandom()});
         end
         return b;
      end
      ang = ($urandom_range(0, 62831) / 10000.0);
      c = $cos(ang); s = $sin(ang);
      ax = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? 1.0 : 0.0;
      if (ax < 3) begin
         int p = (ax + 1) % 3, q = (ax + 2) % 3;
         m[p][p] = c; m[p][q] = -s; m[q][p] = s; m[q][q] = c;
      end
      for (int i = 0; i < 3; i++)
         b.row[i] = {to_q14(m[i][2]), to_q14(m[i][1]), to_q14(m[i][0])};
      t = ($urandom_range(0, 1000) / 1000.0) * (real'(ray_maxd) / 65536.0 * 1.3 + 2.0)
          - ($urandom_range(0, 4) == 0 ? 5.0 : 0.0);
      ux = ray_dir[0] / 16384.0; uy = ray_dir[1] / 16384.0; uz = ray_dir[2] / 16384.0;
      for (int a = 0; a < 3; a++) begin
         real u = (a == 0) ? ux : ((a == 1) ? uy : uz);
         pos = longint'(ray_org[a]) + longint'($rtoi(u * t * 65536.0))
               + longint'($urandom_range(0, 4 * ONE)) - 2 * ONE;
         b.center[a] = pos[31:0];
         b.half[a] = HALF_W'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 16384000)
                                                          : $urandom_range(0, 8 * ONE));
      end
      return b;
   endfunction

   task automatic random_ray();
      real th, ph;
      logic [15:0] d[3];
      logic [30:0] md;
      th = $urandom_range(0, 62831) / 10000.0;
      ph = $urandom_range(0, 31415) / 10000.0;
      case ($urandom_range(0, 3))
         0: d = '{to_q14($sin(ph) * $cos(th)), to_q14($sin(ph) * $sin(th)), to_q14($cos(ph))};
         1: d = '{16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                  16'($urandom_range(0, 32768) - 16384)};
         2: d = '{16'h0, 16'hc000, 16'h0};
         default: d = '{16'h0, 16'h0, 16'h4000};
      endcase
      md = 31'($urandom_range(0, 400) * ONE + $urandom_range(0, 65535));
      set_ray($urandom_range(0, 2000 * 65536) - 1000 * 65536,
              $urandom_range(0, 2000 * 65536) - 1000 * 65536,
              $urandom_range(0, 2000 * 65536) - 1000 * 65536, d[0], d[1], d[2], md);
   endtask

   stim_row_type box_table[$];

   task automatic add_row(box_type b, bit known, result_type r);
      stim_row_type s;
      s.box = b; s.known = known; s.res = r;
      box_table.insert(box_table.size(), s);
   endtask

   initial begin
      result_type none, zero_hit;
      none = '0;
      zero_hit = '0;
      zero_hit.hit = 1'b1;
      ray_org = '{0, 0, 0};
      ray_dir = '{DIR_X_RESET, 16'sd0, 16'sd0};
      ray_maxd = '0;
      req_ch.valid = 1'b0;
      req_ch.box_center_x = '0; req_ch.box_center_y = '0; req_ch.box_center_z = '0;
      req_ch.box_half_x = '0; req_ch.box_half_y = '0; req_ch.box_half_z = '0;
      req_ch.rot_row_first = '0; req_ch.rot_row_second = '0; req_ch.rot_row_third = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers as after reset: zero size box at origin hits at 0, far box misses
      add_row(make_box(0, 0, 0, 0, ROW_X, ROW_Y, ROW_Z), 1, zero_hit);
      add_row(make_box(10 * ONE, 0, 0, ONE, ROW_X, ROW_Y, ROW_Z), 1, none);
      foreach (box_table[i]) begin
         fixed_known_q.insert(fixed_known_q.size(), box_table[i].known);
         fixed_res_q.insert(fixed_res_q.size(), box_table[i].res);
         send_box(box_table[i].box);
      end
      wait_results_done();
      box_table.delete();

      set_ray(0, 0, 0, 16'h4000, 16'h0, 16'h0, 31'(100 * ONE));
      begin
         result_type ahead, origin_in;
         ahead = '{hit: 1'b1, hit_dist: 31'd589824, blocks: 1'b1};
         origin_in = '{hit: 1'b1, hit_dist: 31'd65536, blocks: 1'b1};
         add_row(make_box(10 * ONE, 0, 0, ONE, ROW_X, ROW_Y, ROW_Z), 1, ahead);
         add_row(make_box(-10 * ONE, 0, 0, ONE, ROW_X, ROW_Y, ROW_Z), 1, none);
         add_row(make_box(0, 0, 0, ONE, ROW_X, ROW_Y, ROW_Z), 1, origin_in);
         add_row(make_box(0, 0, 0, 0, ROW_X, ROW_Y, ROW_Z), 1, zero_hit);
      end
      // boundary touching, extremes of every field, zero rotation
      add_row(make_box(10 * ONE, 0, 0, 10 * ONE, ROW_X, ROW_Y, ROW_Z), 0, none);
      add_row(make_box(5 * ONE, 2 * ONE, 0, 2 * ONE, ROW_X, ROW_Y, ROW_Z), 0, none);
      add_row(make_box(200 * ONE, 0, 0, 16384000, ROW_X, ROW_Y, ROW_Z), 0, none);
      add_row(make_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16384000,
                       ROW_X, ROW_Y, ROW_Z), 0, none);
      add_row(make_box(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 16384000,
                       ROW_X, ROW_Y, ROW_Z), 0, none);
      add_row(make_box(3 * ONE, 0, 0, ONE, 48'h0, 48'h0, 48'h0), 0, none);
      add_row(make_box(0, 0, 0, ONE, 48'h0, 48'h0, 48'h0), 0, none);
      add_row(make_box(-4 * ONE, 0, 0, ONE, {3{16'hc000}}, {3{16'hc000}}, {3{16'hc000}}),
              0, none);
      add_row(make_box(7 * ONE, ONE, -ONE, 3 * ONE, {3{16'h7fff}}, {3{16'h8000}},
                       {16'h7fff, 16'h8000, 16'h7fff}), 0, none);
      add_row(make_box(50 * ONE, 0, 0, ONE, {3{16'hffff}}, ROW_Y, ROW_Z), 0, none);
      add_row(make_box(-1, -1, -1, 24'hffffff, ROW_Z, ROW_X, ROW_Y), 0, none);
      add_row(make_box(99 * ONE + 40000, 0, 0, ONE, ROW_X, ROW_Y, ROW_Z), 0, none);
      foreach (box_table[i]) begin
         fixed_known_q.insert(fixed_known_q.size(), box_table[i].known);
         fixed_res_q.insert(fixed_res_q.size(), box_table[i].res);
         send_box(box_table[i].box);
      end
      wait_results_done();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            1: set_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                       16'hc000, 16'hc000, 16'hc000, 31'h7fff_ffff);
            2: set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       16'h4000, 16'h4000, 16'h4000, 31'h0);
            3: set_ray(0, 0, 0, 16'h0, 16'h0, 16'h0, 31'(50 * ONE));
            default: random_ray();
         endcase
         if (ph == 7) quiet = 1;
         repeat (225) send_box(random_box());
         wait_results_done();
      end

      if (errors == 0) begin
         $display("ray_obb_slab_test_top_tb OK");
      end else begin
         $display("ray_obb_slab_test_top_tb NOT OK");
      end
      $finish;
   end

endmodule
